>>> rtl/opfs_pkg.sv
// ----------------------------------------------------------------------------
// opfs_pkg
// Shared types and constants for the OLED page-mode frame serializer.
// ----------------------------------------------------------------------------
package opfs_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 4;

    localparam int KIND_W   = 2;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 5;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMIT  = 2'd2;

    localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic start_write;
        logic finish_write;
        logic start_emit;
        logic finish_emit;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

>>> rtl/opfs_ram.sv
// ----------------------------------------------------------------------------
// opfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module opfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/opfs_ctrl.sv
// ----------------------------------------------------------------------------
// opfs_ctrl
// Item sequencer: accepts items and steps the datapath through each one.
// ----------------------------------------------------------------------------
module opfs_ctrl
    import opfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_stall = (r_state != S_IDLE) ||
                        ((i_in.kind == KIND_EMIT) && i_status.out_busy);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.kind)
                        KIND_WRITE: begin
                            o_cmd.start_write = 1'b1;
                            n_state           = S_WRITE;
                        end
                        KIND_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        KIND_EMIT: begin
                            o_cmd.start_emit = 1'b1;
                            n_state          = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.finish_write = 1'b1;
                n_state            = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.finish_emit = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/opfs_dp.sv
// ----------------------------------------------------------------------------
// opfs_dp
// Pixel store, per-column valid bits, frame position and output register.
// ----------------------------------------------------------------------------
module opfs_dp
    import opfs_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out
);

    localparam int ROWS = PAGES * 8;
    localparam int AW   = $clog2(COLUMNS);
    localparam int OW   = $clog2(COLUMNS + 4);
    localparam int PW   = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [COLUMNS-1:0] r_col_valid;
    logic [PW-1:0]      r_page;
    logic [OW-1:0]      r_off;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [AW-1:0]      r_wr_addr;
    logic [ROW_W-1:0]   r_row;
    logic               r_pix;
    logic               r_in_range;
    logic               r_hit;
    logic [7:0]         r_e_byte;
    logic               r_e_data;
    logic               r_e_last;
    logic [PW-1:0]      r_e_page;

    logic [ROWS-1:0]    w_rdata;
    logic [ROWS-1:0]    w_word;
    logic [ROWS-1:0]    w_mask;
    logic [ROWS-1:0]    w_wdata;
    logic [ROWS-1:0]    w_shift;
    logic [AW-1:0]      w_col_addr;
    logic [AW-1:0]      w_emit_addr;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic               w_last;
    logic               w_in_range;
    logic [7:0]         w_cmd_byte;

    assign w_col_addr  = AW'(i_in.column);
    assign w_emit_addr = AW'(r_off - OW'(4));
    assign w_raddr     = i_cmd.start_emit ? w_emit_addr : w_col_addr;
    assign w_in_range  = ({2'b00, i_in.column} < 9'(COLUMNS)) &&
                         ({2'b00, i_in.row} < 7'(ROWS));
    assign w_last      = (r_page == PW'(PAGES - 1)) && (r_off == OW'(COLUMNS + 3));

    always_comb begin
        if (r_off == OW'(0)) begin
            w_cmd_byte = CMD_PAGE_ADDR;
        end else if (r_off == OW'(1)) begin
            w_cmd_byte = {{(8-PW){1'b0}}, r_page};
        end else if (r_off == OW'(2)) begin
            w_cmd_byte = CMD_COL_LOW;
        end else begin
            w_cmd_byte = CMD_COL_HIGH;
        end
    end

    assign w_word  = r_hit ? w_rdata : '0;
    assign w_mask  = {{(ROWS-1){1'b0}}, 1'b1} << r_row;
    assign w_wdata = r_pix ? (w_word | w_mask) : (w_word & ~w_mask);
    assign w_we    = i_cmd.finish_write && r_in_range;
    assign w_shift = w_word >> {r_e_page, 3'b000};

    opfs_ram #(
        .WIDTH(ROWS),
        .DEPTH(COLUMNS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_wr_addr),
        .i_wdata(w_wdata),
        .i_re   (i_cmd.start_write || i_cmd.start_emit),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_write || i_cmd.start_emit) begin
            r_hit <= r_col_valid[w_raddr];
        end
        if (i_cmd.start_write) begin
            r_wr_addr  <= w_col_addr;
            r_row      <= i_in.row;
            r_pix      <= i_in.pixel_value;
            r_in_range <= w_in_range;
        end
        if (i_cmd.start_emit) begin
            r_e_byte <= w_cmd_byte;
            r_e_data <= (r_off >= OW'(4));
            r_e_last <= w_last;
            r_e_page <= r_page;
        end
        if (i_cmd.finish_emit) begin
            r_out.out_byte  <= r_e_data ? w_shift[7:0] : r_e_byte;
            r_out.is_data   <= r_e_data;
            r_out.frame_end <= r_e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_valid <= '0;
            r_page      <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_col_valid <= '0;
            end else if (w_we) begin
                r_col_valid[r_wr_addr] <= 1'b1;
            end
            if (i_cmd.start_emit) begin
                if (r_off == OW'(COLUMNS + 3)) begin
                    r_off  <= '0;
                    r_page <= w_last ? '0 : r_page + PW'(1);
                end else begin
                    r_off <= r_off + OW'(1);
                end
            end
            if (i_cmd.finish_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

>>> rtl/oled_page_frame_serializer_top.sv
// ----------------------------------------------------------------------------
// oled_page_frame_serializer_top
// Page-mode OLED frame buffer: pixel writes, buffer clear, frame byte stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  in      | input     | i_in_valid / o_in_stall      | i_in  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall    | o_out (t_out_item)
//
//  Write and emit items also pass through S_WRITE or S_EMIT, set by the
//  registered read of the pixel RAM ahead of the pixel merge or the byte
//  select; clear and unused kinds are done in S_IDLE.
//  Reset clears all per-column valid bits; no RAM sweep.
//  An emit item waits while the output register holds an untaken item;
//  write and clear items still go through.
// ----------------------------------------------------------------------------
module oled_page_frame_serializer_top
    import opfs_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int PAGES   = PAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    opfs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in      (i_in),
        .o_in_stall(o_in_stall),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    opfs_dp #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

endmodule
